/* src/scan_window_obstacle_stop_defines.svh */
// Assertion helpers used by the scan_window_obstacle_stop RTL.
`ifndef SCAN_WINDOW_OBSTACLE_STOP_DEFINES_SVH
`define SCAN_WINDOW_OBSTACLE_STOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWOS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swos assertion failed");

// Next-cycle implication, disabled during reset.
`define SWOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swos assertion failed");

`endif

/* src/swos_pkg.sv */
package swos_pkg;

  localparam int unsigned HALF_WINDOW_W = 22;
  localparam int unsigned DIST_W        = 16;
  localparam int unsigned FRAMES_W      = 8;
  localparam int unsigned START_W       = 23;
  localparam int unsigned STEP_W        = 18;
  localparam int unsigned ANGLE_W       = 32;
  localparam int unsigned ADDR_W        = 5;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] REG_HALF_WINDOW  = 3'd0;
  localparam logic [2:0] REG_STOP_DIST    = 3'd1;
  localparam logic [2:0] REG_SLOW_DIST    = 3'd2;
  localparam logic [2:0] REG_MIN_RANGE    = 3'd3;
  localparam logic [2:0] REG_STOP_FRAMES  = 3'd4;
  localparam logic [2:0] REG_CLEAR_FRAMES = 3'd5;
  localparam logic [2:0] REG_START_ANGLE  = 3'd6;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd7;

  localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RST  = 22'd261799;
  localparam logic [DIST_W-1:0]        STOP_DIST_RST    = 16'd800;
  localparam logic [DIST_W-1:0]        SLOW_DIST_RST    = 16'd1500;
  localparam logic [DIST_W-1:0]        MIN_RANGE_RST    = 16'd150;
  localparam logic [FRAMES_W-1:0]      STOP_FRAMES_RST  = 8'd2;
  localparam logic [FRAMES_W-1:0]      CLEAR_FRAMES_RST = 8'd3;
  localparam logic [START_W-1:0]       START_ANGLE_RST  = 23'h501027; // -3141593
  localparam logic [STEP_W-1:0]        ANGLE_STEP_RST   = 18'd4363;

  localparam logic [1:0] ZONE_CLEAR = 2'd0;
  localparam logic [1:0] ZONE_SLOW  = 2'd1;
  localparam logic [1:0] ZONE_STOP  = 2'd2;

  // lowest bit first: stop_active, slow_zone, nearest_mm, zone_code
  typedef struct packed {
    logic [1:0]        zone_code;
    logic [DIST_W-1:0] nearest_mm;
    logic              slow_zone;
    logic              stop_active;
  } result_t;

endpackage

/* src/scan_window_obstacle_stop.sv */
// Front-window obstacle stop detector. Range samples stream in on the s_ side,
// one beat per sample in scan order, with s_tlast on the final sample of a
// scan; samples are taken back to back, one per clock while s_tready is high;
// a scan's decision is registered in the result register or skid. Angles run
// from scan_start_angle in steps of angle_step; samples within +/-half_window
// that are finite and at least min_valid_range feed a running minimum. At end
// of scan the stop/clear frame counters update and the debounced stop flag is
// set or released. A two-entry result buffer keeps s_tready high while one
// result waits; only a second pending result stalls the input. Registers sit
// at byte addresses 4*index on the APB port and may be written while idle.
`include "scan_window_obstacle_stop_defines.svh"

module scan_window_obstacle_stop (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swos_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // samples
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // range_mm[15:0], range_finite[16], zero
  input  logic                        s_tlast,  // last_in_scan
  // scan results
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata   // stop_active, slow_zone, nearest_mm,
                                                // zone_code, zero
);

  localparam int unsigned DW = swos_pkg::DIST_W;
  localparam int unsigned AW = swos_pkg::ANGLE_W;

  logic [swos_pkg::HALF_WINDOW_W-1:0] half_window;
  logic [DW-1:0]                      stop_thresh;
  logic [DW-1:0]                      slow_thresh;
  logic [DW-1:0]                      min_valid_range;
  logic [swos_pkg::FRAMES_W-1:0]      stop_frames_needed;
  logic [swos_pkg::FRAMES_W-1:0]      clear_frames_needed;
  logic [swos_pkg::START_W-1:0]       scan_start_angle;
  logic [swos_pkg::STEP_W-1:0]        angle_step;

  logic [AW-1:0]                      current_angle;
  logic [DW-1:0]                      nearest_range;
  logic                               nearest_found;
  logic [swos_pkg::FRAMES_W-1:0]      stop_count;
  logic [swos_pkg::FRAMES_W-1:0]      clear_count;
  logic                               stop_flag;

  swos_pkg::result_t                  out_reg;
  swos_pkg::result_t                  skid;
  logic                               skid_valid;

  logic                               cfg_wr;
  logic [2:0]                         cfg_idx;
  logic [AW-1:0]                      start_ext;
  logic [AW-1:0]                      step_ext;
  logic [AW-1:0]                      angle_mag;
  logic                               in_window;
  logic                               sample_ok;
  logic [DW-1:0]                      range_mm;
  logic                               range_finite;
  logic                               s_accept;
  logic                               res_new;
  logic                               pop;
  logic [DW-1:0]                      nearest_range_next;
  logic                               nearest_found_next;
  logic                               slow;
  logic                               cand;
  logic [swos_pkg::FRAMES_W-1:0]      stop_count_next;
  logic [swos_pkg::FRAMES_W-1:0]      clear_count_next;
  logic [swos_pkg::FRAMES_W-1:0]      need_stop;
  logic [swos_pkg::FRAMES_W-1:0]      need_clear;
  logic                               stop_flag_next;
  swos_pkg::result_t                  res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      swos_pkg::REG_HALF_WINDOW:  prdata = {10'd0, half_window};
      swos_pkg::REG_STOP_DIST:    prdata = {16'd0, stop_thresh};
      swos_pkg::REG_SLOW_DIST:    prdata = {16'd0, slow_thresh};
      swos_pkg::REG_MIN_RANGE:    prdata = {16'd0, min_valid_range};
      swos_pkg::REG_STOP_FRAMES:  prdata = {24'd0, stop_frames_needed};
      swos_pkg::REG_CLEAR_FRAMES: prdata = {24'd0, clear_frames_needed};
      swos_pkg::REG_START_ANGLE:  prdata = {9'd0, scan_start_angle};
      swos_pkg::REG_ANGLE_STEP:   prdata = {14'd0, angle_step};
      default:                    prdata = 32'd0;
    endcase
  end

  assign start_ext = {{(AW - swos_pkg::START_W){scan_start_angle[swos_pkg::START_W-1]}},
                      scan_start_angle};
  assign step_ext  = {{(AW - swos_pkg::STEP_W){angle_step[swos_pkg::STEP_W-1]}},
                      angle_step};

  assign range_mm     = s_tdata[15:0];
  assign range_finite = s_tdata[16];
  assign s_tready     = !skid_valid;
  assign s_accept     = s_tvalid && s_tready;
  assign res_new      = s_accept && s_tlast;
  assign pop          = m_tvalid && m_tready;

  // most negative angle keeps its pattern and falls outside any window
  assign angle_mag = current_angle[AW-1] ? (~current_angle + 32'd1) : current_angle;
  assign in_window = angle_mag <= {{(AW - swos_pkg::HALF_WINDOW_W){1'b0}}, half_window};
  assign sample_ok = in_window && range_finite && (range_mm >= min_valid_range);

  always_comb begin
    nearest_range_next = nearest_range;
    nearest_found_next = nearest_found;
    if (sample_ok) begin
      if (!nearest_found || range_mm < nearest_range) begin
        nearest_range_next = range_mm;
      end
      nearest_found_next = 1'b1;
    end

    slow = nearest_found_next && (nearest_range_next <= slow_thresh);
    cand = nearest_found_next && (nearest_range_next <= stop_thresh);

    if (cand) begin
      stop_count_next  = (stop_count == 8'hff) ? stop_count : stop_count + 8'd1;
      clear_count_next = 8'd0;
    end else begin
      clear_count_next = (clear_count == 8'hff) ? clear_count : clear_count + 8'd1;
      stop_count_next  = 8'd0;
    end

    need_stop  = (stop_frames_needed == 8'd0) ? 8'd1 : stop_frames_needed;
    need_clear = (clear_frames_needed == 8'd0) ? 8'd1 : clear_frames_needed;

    stop_flag_next = stop_flag;
    if (!stop_flag && stop_count_next >= need_stop) begin
      stop_flag_next = 1'b1;
    end else if (stop_flag && clear_count_next >= need_clear) begin
      stop_flag_next = 1'b0;
    end

    res.stop_active = stop_flag_next;
    res.slow_zone   = slow;
    res.nearest_mm  = slow ? nearest_range_next : '0;
    if (stop_flag_next) begin
      res.zone_code = swos_pkg::ZONE_STOP;
    end else if (slow) begin
      res.zone_code = swos_pkg::ZONE_SLOW;
    end else begin
      res.zone_code = swos_pkg::ZONE_CLEAR;
    end
  end

  // configuration and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window         <= swos_pkg::HALF_WINDOW_RST;
      stop_thresh         <= swos_pkg::STOP_DIST_RST;
      slow_thresh         <= swos_pkg::SLOW_DIST_RST;
      min_valid_range     <= swos_pkg::MIN_RANGE_RST;
      stop_frames_needed  <= swos_pkg::STOP_FRAMES_RST;
      clear_frames_needed <= swos_pkg::CLEAR_FRAMES_RST;
      scan_start_angle    <= swos_pkg::START_ANGLE_RST;
      angle_step          <= swos_pkg::ANGLE_STEP_RST;
      current_angle       <= {{(AW - swos_pkg::START_W){swos_pkg::START_ANGLE_RST[
                               swos_pkg::START_W-1]}}, swos_pkg::START_ANGLE_RST};
      nearest_range       <= '0;
      nearest_found       <= 1'b0;
      stop_count          <= '0;
      clear_count         <= '0;
      stop_flag           <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        swos_pkg::REG_HALF_WINDOW:  half_window <= pwdata[swos_pkg::HALF_WINDOW_W-1:0];
        swos_pkg::REG_STOP_DIST:    stop_thresh <= pwdata[DW-1:0];
        swos_pkg::REG_SLOW_DIST:    slow_thresh <= pwdata[DW-1:0];
        swos_pkg::REG_MIN_RANGE:    min_valid_range <= pwdata[DW-1:0];
        swos_pkg::REG_STOP_FRAMES:  stop_frames_needed <= pwdata[swos_pkg::FRAMES_W-1:0];
        swos_pkg::REG_CLEAR_FRAMES: clear_frames_needed <= pwdata[swos_pkg::FRAMES_W-1:0];
        swos_pkg::REG_START_ANGLE: begin
          scan_start_angle <= pwdata[swos_pkg::START_W-1:0];
          current_angle    <= {{(AW - swos_pkg::START_W){pwdata[swos_pkg::START_W-1]}},
                               pwdata[swos_pkg::START_W-1:0]};
        end
        swos_pkg::REG_ANGLE_STEP:   angle_step <= pwdata[swos_pkg::STEP_W-1:0];
        default: ;
      endcase
    end else if (s_accept) begin
      if (s_tlast) begin
        current_angle <= start_ext;
        nearest_range <= '0;
        nearest_found <= 1'b0;
        stop_count    <= stop_count_next;
        clear_count   <= clear_count_next;
        stop_flag     <= stop_flag_next;
      end else begin
        current_angle <= current_angle + step_ext;
        nearest_range <= nearest_range_next;
        nearest_found <= nearest_found_next;
      end
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= res_new;
      end
    end else if (res_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (res_new) begin
        out_reg <= res;
      end
    end else if (res_new) begin
      skid <= res;
    end
  end

  assign m_tdata = {4'd0, out_reg};

  // a result arriving behind a stalled beat must land in the skid entry
  `SWOS_ASSERT_NEXT(a_skid_catch, m_tvalid && !m_tready && res_new, skid_valid)
  // skid entry only holds data behind a full output register
  `SWOS_ASSERT_IMPL(a_skid_order, skid_valid, m_tvalid)
  // end of scan restarts the window state
  `SWOS_ASSERT_NEXT(a_scan_restart, res_new && !cfg_wr,
                    !nearest_found && current_angle == start_ext)
  // the two frame counters never run at once
  `SWOS_ASSERT_IMPL(a_count_excl, stop_count != 8'd0, clear_count == 8'd0)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_PCT      = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 85;
  localparam int SATURATE_SCANS = 260;

  localparam swos_pkg::result_t NO_OBSTACLE = '{swos_pkg::ZONE_CLEAR, 16'd0, 1'b0, 1'b0};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [31:0]       val;
    logic [15:0]       rng;
    logic              fin;
    logic              lst;
    logic              typed;   // want holds the expected result for this row
    swos_pkg::result_t want;
  } row_t;

  localparam row_t SCRIPT [35] = '{
    // reset settings: the window never reaches the first samples of a scan
    '{ROW_SAMPLE, '0, 32'd0, 16'd500, 1'b1, 1'b1, 1'b1, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd0, 1'b1, 1'b1, 1'b1, NO_OBSTACLE},
    // angles -10000, -5000, 0, ... with both window edges inside
    '{ROW_WRITE, swos_pkg::REG_HALF_WINDOW, 32'd10000, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_ANGLE_STEP, 32'd5000, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_START_ANGLE, -32'sd10000, 16'd0, 1'b0, 1'b0, 1'b0,
      NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd100, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd149, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd150, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd700, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd800, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd1500, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd1501, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd300, 1'b0, 1'b1, 1'b0, NO_OBSTACLE},
    // zero-width window: only the sample at angle 0 counts
    '{ROW_WRITE, swos_pkg::REG_HALF_WINDOW, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd300, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd400, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd500, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    // start angle written mid-scan reloads the running angle
    '{ROW_SAMPLE, '0, 32'd0, 16'd200, 1'b1, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_START_ANGLE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd600, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    // zero frame thresholds behave as one
    '{ROW_WRITE, swos_pkg::REG_STOP_FRAMES, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_CLEAR_FRAMES, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd900, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd300, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    // distance extremes
    '{ROW_WRITE, swos_pkg::REG_MIN_RANGE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_STOP_DIST, 32'd65535, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_SLOW_DIST, 32'd65535, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd0, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_STOP_DIST, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_WRITE, swos_pkg::REG_SLOW_DIST, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd0, 1'b1, 1'b1, 1'b0, NO_OBSTACLE},
    '{ROW_SAMPLE, '0, 32'd0, 16'd1, 1'b1, 1'b1, 1'b0, NO_OBSTACLE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // range_mm[15:0], range_finite[16], zero
  logic        s_tlast = 1'b0; // last_in_scan
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // stop_active, slow_zone, nearest_mm, zone_code, zero

  logic no_gaps = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // settings as the predictor sees them
  logic [21:0] half_window  = swos_pkg::HALF_WINDOW_RST;
  logic [15:0] stop_dist    = swos_pkg::STOP_DIST_RST;
  logic [15:0] slow_dist    = swos_pkg::SLOW_DIST_RST;
  logic [15:0] min_range    = swos_pkg::MIN_RANGE_RST;
  logic [7:0]  stop_need    = swos_pkg::STOP_FRAMES_RST;
  logic [7:0]  clear_need   = swos_pkg::CLEAR_FRAMES_RST;
  logic [22:0] start_angle  = swos_pkg::START_ANGLE_RST;
  logic [17:0] angle_step   = swos_pkg::ANGLE_STEP_RST;

  // scan state
  logic [31:0] cur_angle  = {{9{swos_pkg::START_ANGLE_RST[22]}}, swos_pkg::START_ANGLE_RST};
  logic [15:0] near_mm    = '0;
  logic        near_found = 1'b0;
  logic [7:0]  stop_run   = '0;
  logic [7:0]  clear_run  = '0;
  logic        stop_flag  = 1'b0;

  swos_pkg::result_t scan_results[$];

  scan_window_obstacle_stop dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // returns 1 when the sample closes a scan, with the decision in res
  function automatic logic scan_decision(input logic [15:0] rng, input logic fin,
                                         input logic lst, output swos_pkg::result_t res);
    logic [31:0] mag;
    logic        slow;
    logic        cand;
    logic [7:0]  need_stop;
    logic [7:0]  need_clear;
    res = NO_OBSTACLE;
    mag = cur_angle[31] ? 32'd0 - cur_angle : cur_angle;
    if (mag <= {10'd0, half_window} && fin && rng >= min_range) begin
      if (!near_found || rng < near_mm) near_mm = rng;
      near_found = 1'b1;
    end
    cur_angle = cur_angle + {{14{angle_step[17]}}, angle_step};
    if (!lst) return 1'b0;

    slow = near_found && near_mm <= slow_dist;
    cand = near_found && near_mm <= stop_dist;
    if (cand) begin
      if (stop_run != 8'hFF) stop_run = stop_run + 8'd1;
      clear_run = '0;
    end else begin
      if (clear_run != 8'hFF) clear_run = clear_run + 8'd1;
      stop_run = '0;
    end
    need_stop  = (stop_need == 0) ? 8'd1 : stop_need;
    need_clear = (clear_need == 0) ? 8'd1 : clear_need;
    if (!stop_flag && stop_run >= need_stop) stop_flag = 1'b1;
    else if (stop_flag && clear_run >= need_clear) stop_flag = 1'b0;

    res.stop_active = stop_flag;
    res.slow_zone   = slow;
    res.nearest_mm  = slow ? near_mm : 16'd0;
    res.zone_code   = stop_flag ? swos_pkg::ZONE_STOP
                                : (slow ? swos_pkg::ZONE_SLOW : swos_pkg::ZONE_CLEAR);

    cur_angle  = {{9{start_angle[22]}}, start_angle};
    near_found = 1'b0;
    near_mm    = '0;
    return 1'b1;
  endfunction

  // half the time a range near a current threshold, else anywhere or up to 3000
  function automatic logic [15:0] pick_range();
    int base;
    case ($urandom_range(5))
      0: base = stop_dist;
      1: base = slow_dist;
      2: base = min_range;
      3: return 16'($urandom);
      default: return 16'($urandom_range(3000));
    endcase
    base = base + int'($urandom_range(6)) - 3;
    if (base < 0) base = 0;
    if (base > 65535) base = 65535;
    return 16'(base);
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_sample(input logic [15:0] rng, input logic fin, input logic lst,
                             input logic typed, input swos_pkg::result_t want);
    swos_pkg::result_t res;
    while (!no_gaps && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, fin, rng};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    if (scan_decision(rng, fin, lst, res)) scan_results.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    while (scan_results.size() != 0) @(posedge clk);
    // a sample without tlast leaves no result to wait for
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      swos_pkg::REG_HALF_WINDOW:  half_window  = val[21:0];
      swos_pkg::REG_STOP_DIST:    stop_dist    = val[15:0];
      swos_pkg::REG_SLOW_DIST:    slow_dist    = val[15:0];
      swos_pkg::REG_MIN_RANGE:    min_range    = val[15:0];
      swos_pkg::REG_STOP_FRAMES:  stop_need    = val[7:0];
      swos_pkg::REG_CLEAR_FRAMES: clear_need   = val[7:0];
      swos_pkg::REG_START_ANGLE: begin
        start_angle = val[22:0];
        cur_angle   = {{9{val[22]}}, val[22:0]};
      end
      swos_pkg::REG_ANGLE_STEP:   angle_step   = val[17:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_scan_result(input swos_pkg::result_t got);
    swos_pkg::result_t want;
    if (scan_results.size() == 0) begin
      report($sformatf("scan result %h with none pending", got));
      return;
    end
    want = scan_results.pop_front();
    if (got.stop_active !== want.stop_active)
      report($sformatf("stop_active %b, expected %b", got.stop_active, want.stop_active));
    if (got.slow_zone !== want.slow_zone)
      report($sformatf("slow_zone %b, expected %b", got.slow_zone, want.slow_zone));
    if (got.nearest_mm !== want.nearest_mm)
      report($sformatf("nearest_mm %0d, expected %0d", got.nearest_mm, want.nearest_mm));
    if (got.zone_code !== want.zone_code)
      report($sformatf("zone_code %0d, expected %0d", got.zone_code, want.zone_code));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_scan_result(swos_pkg::result_t'(m_tdata[19:0]));
      m_tready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int len;
    int s;
    int st;
    int hw;
    int lim_mm;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_WRITE)
        write_reg(SCRIPT[i].idx, SCRIPT[i].val);
      else
        send_sample(SCRIPT[i].rng, SCRIPT[i].fin, SCRIPT[i].lst,
                    SCRIPT[i].typed, SCRIPT[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps <= (p == 3);
      case ($urandom_range(4))
        0: hw = 0;
        1: hw = 22'h3FFFFF;
        2: hw = $urandom_range(22'h3FFFFF);
        default: hw = $urandom_range(40000);
      endcase
      write_reg(swos_pkg::REG_HALF_WINDOW, 32'(hw));
      case ($urandom_range(5))
        0: lim_mm = 0;
        1: lim_mm = 65535;
        default: lim_mm = $urandom_range(2000);
      endcase
      write_reg(swos_pkg::REG_STOP_DIST, 32'(lim_mm));
      lim_mm = ($urandom_range(5) == 0) ? $urandom_range(65535)
                                        : lim_mm + $urandom_range(1500);
      write_reg(swos_pkg::REG_SLOW_DIST, 32'(lim_mm > 65535 ? 65535 : lim_mm));
      case ($urandom_range(5))
        0: write_reg(swos_pkg::REG_MIN_RANGE, 32'($urandom_range(65535)));
        1: write_reg(swos_pkg::REG_MIN_RANGE, 32'd65535);
        default: write_reg(swos_pkg::REG_MIN_RANGE, 32'($urandom_range(400)));
      endcase
      write_reg(swos_pkg::REG_STOP_FRAMES,
                ($urandom_range(5) == 0) ? 32'd255 : 32'($urandom_range(4)));
      write_reg(swos_pkg::REG_CLEAR_FRAMES,
                ($urandom_range(5) == 0) ? 32'd255 : 32'($urandom_range(4)));
      case ($urandom_range(5))
        0: s = -131072;
        1: s = 131071;
        2: s = 0;
        default: s = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(30000));
      endcase
      write_reg(swos_pkg::REG_ANGLE_STEP, 32'(s));
      // often start up to six steps before 0 so the window falls inside short scans
      case ($urandom_range(5))
        0: st = -4194304;
        1: st = 4194303;
        2: st = int'($urandom_range(23'h7FFFFF)) - 4194304;
        default: st = -s * int'($urandom_range(6)) + int'($urandom_range(4000)) - 2000;
      endcase
      write_reg(swos_pkg::REG_START_ANGLE, 32'(st));

      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int j = 0; j < len; j++)
          send_sample(pick_range(), $urandom_range(99) < 85, j == len - 1, 1'b0, NO_OBSTACLE);
        sent += len;
      end
      // sometimes leave a scan open across the next settings change
      if ($urandom_range(1))
        repeat ($urandom_range(1, 4))
          send_sample(pick_range(), 1'b1, 1'b0, 1'b0, NO_OBSTACLE);
    end

    // long runs of stop candidates, then of clear scans, past counter saturation
    write_reg(swos_pkg::REG_HALF_WINDOW, 32'h3FFFFF);
    write_reg(swos_pkg::REG_START_ANGLE, 32'd0);
    write_reg(swos_pkg::REG_ANGLE_STEP, 32'd0);
    write_reg(swos_pkg::REG_MIN_RANGE, 32'd0);
    write_reg(swos_pkg::REG_STOP_DIST, 32'd65535);
    write_reg(swos_pkg::REG_SLOW_DIST, 32'd65535);
    write_reg(swos_pkg::REG_STOP_FRAMES, 32'd255);
    write_reg(swos_pkg::REG_CLEAR_FRAMES, 32'd255);
    no_gaps <= 1'b0;
    repeat (SATURATE_SCANS)
      send_sample(16'($urandom), 1'b1, 1'b1, 1'b0, NO_OBSTACLE);
    repeat (SATURATE_SCANS)
      send_sample(16'($urandom), 1'b0, 1'b1, 1'b0, NO_OBSTACLE);

    s_tvalid <= 1'b0;
    while (scan_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
